FILE: hw/rtl/i2d_pkg.sv
// shared types and constants for the int128 to binary64 converter
// no dependencies
package i2d_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned LEN_W  = 7;
    localparam int unsigned FRAC_W = 52;
    localparam int unsigned EXP_W  = 11;
    localparam logic [EXP_W-1:0] EXP_BIAS = 11'd1023;
    localparam int unsigned FIFO_DEPTH = 2;

    // classified word passed from front to back
    typedef struct packed {
        logic              neg;
        logic              zero;
        logic [WORD_W-1:0] win;
        logic [LEN_W-1:0]  scale;
    } t_cls;

    // index of the highest set bit, zero for a zero word
    function automatic logic [5:0] top_bit(input logic [WORD_W-1:0] v);
        logic [5:0] t;
        t = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) begin
                t = 6'(i);
            end
        end
        return t;
    endfunction

endpackage

FILE: hw/rtl/i2d_front.sv
// front stage: sign split, 128-bit negation, window select
// depends on i2d_pkg
module i2d_front import i2d_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [127:0]  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output t_cls          o_cls
);
    logic r_neg_v, r_neg;
    logic [127:0] r_mag;
    logic [127:0] n_mag;
    logic         s1_ready;
    logic         r_valid;
    t_cls         r_cls;
    logic [WORD_W-1:0] hi, lo, win;
    logic [5:0]        tb;
    logic [LEN_W-1:0]  len;

    // stage 1: magnitude by full negation
    assign n_mag = i_data[127] ? (~i_data + 128'd1) : i_data;
    assign s1_ready = !r_neg_v || !r_valid || i_ready;
    assign o_ready  = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg_v <= 1'b0;
        end else if (s1_ready) begin
            r_neg_v <= i_valid;
        end
        if (s1_ready && i_valid) begin
            r_mag <= n_mag;
            r_neg <= i_data[127];
        end
    end

    // stage 2: window select
    assign hi  = r_mag[127:64];
    assign lo  = r_mag[63:0];
    assign tb  = top_bit(hi);
    assign len = (hi == '0) ? '0 : LEN_W'(tb) + LEN_W'(1);
    assign win = (hi == '0) ? lo : WORD_W'(r_mag >> len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= r_neg_v;
        end
        if ((!r_valid || i_ready) && r_neg_v) begin
            r_cls.neg   <= r_neg;
            r_cls.zero  <= (r_mag == '0);
            r_cls.win   <= win;
            r_cls.scale <= len;
        end
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;
endmodule

FILE: hw/rtl/i2d_fifo.sv
// short queue between front and back
// depends on i2d_pkg
module i2d_fifo import i2d_pkg::*; #(
    parameter int unsigned DEPTH = FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cls i_cls,
    output logic o_valid,
    input  logic i_ready,
    output t_cls o_cls
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    t_cls r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic wr, rd;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;
    assign o_cls = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            end
            if (rd) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
        if (wr) begin
            r_mem[r_wp] <= i_cls;
        end
    end
endmodule

FILE: hw/rtl/i2d_back.sv
// back stage: round window to nearest-even and pack binary64
// depends on i2d_pkg
module i2d_back import i2d_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_cls              i_cls,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_data
);
    logic [5:0]  top;
    logic [WORD_W-1:0] norm;
    logic [FRAC_W:0] mant0;
    logic [FRAC_W+1:0] mant1;
    logic guard, sticky, up;
    logic [EXP_W-1:0] expo;
    logic r_valid;
    logic [WORD_W-1:0] r_data;

    // normalize top bit to 63, then round at bit 11
    assign top  = top_bit(i_cls.win);
    assign norm = i_cls.win << (6'd63 - top);
    assign mant0 = norm[63:11];
    assign guard = norm[10];
    assign sticky = |norm[9:0];
    assign up = guard && (sticky || mant0[0]);
    assign mant1 = {1'b0, mant0} + (FRAC_W+2)'(up);
    assign expo = EXP_BIAS + EXP_W'(top) + EXP_W'(i_cls.scale) + EXP_W'(mant1[FRAC_W+1]);

    assign o_ready = !r_valid || i_ready;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            if (i_cls.zero) begin
                r_data <= '0;
            end else begin
                r_data <= {i_cls.neg, expo,
                           mant1[FRAC_W+1] ? mant1[FRAC_W:1] : mant1[FRAC_W-1:0]};
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

FILE: hw/rtl/int128_to_double_convert_core.sv
// top level of the signed 128-bit integer to binary64 converter
// depends on i2d_pkg, i2d_front, i2d_fifo, i2d_back
//
// usage:
//   slave channel s_axis_*: one word per operand, tdata[63:0] high word
//   (signed), tdata[127:64] low word (unsigned)
//   master channel m_axis_*: one word per result, tdata[63:0] the binary64
//   bit pattern of the operand's value (round to nearest-even on the window)
//   throughput: one word per cycle while m_axis_tready stays high, fully pipelined
//   path: from the accepting edge to tvalid through four registers
//   (negate, window select, queue, round and pack)
//   reset: synchronous active low, clears all valid flags; no clearing pass
//   receiver stall: the output register holds, the queue absorbs words in
//   flight, and s_axis_tready drops once the queue and front stages are full
//   no data is lost or repeated under any stall pattern
module int128_to_double_convert_core import i2d_pkg::*; #(
    parameter int unsigned DEPTH = FIFO_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // high_word [63:0], low_word [127:64]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata   // double_bits [63:0]
);
    logic f_valid, f_ready, q_valid, q_ready;
    t_cls f_cls, q_cls;
    logic [127:0] cat;

    // reorder to {high, low}
    assign cat = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    i2d_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(cat),
        .o_valid(f_valid), .i_ready(f_ready), .o_cls(f_cls)
    );

    i2d_fifo #(.DEPTH(DEPTH)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_cls(f_cls),
        .o_valid(q_valid), .i_ready(q_ready), .o_cls(q_cls)
    );

    i2d_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_cls(q_cls),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );
endmodule
